@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int VALUE_W         = 32;
	localparam int PRIO_W          = 8;
	localparam int ENTRY_W         = VALUE_W + PRIO_W;

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_TRV = 2'd2,
		OP_RSV = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_REMOVED   = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_LISTED    = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		AS_POS,
		AS_POSM1,
		AS_IDX,
		AS_HEAD
	} addr_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERD,
		S_ECMP,
		S_INS,
		S_DRD,
		S_DOUT,
		S_TRD,
		S_TOUT,
		S_OVF,
		S_UND,
		S_EMP
	} state_t;

	typedef struct packed {
		logic in_valid;
		op_t  op;
		logic full;
		logic empty;
		logic pos_one;
		logic gt;
		logic out_free;
		logic idx_last;
	} stat_t;

	typedef struct packed {
		logic      in_ready;
		logic      item_ld;
		logic      rd_en;
		logic      wr_en;
		logic      wr_item;
		addr_sel_t asel;
		logic      pos_dec;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      head_inc;
		logic      idx_inc;
		logic      out_ld;
		status_t   out_status;
		logic      out_data;
		logic      out_last;
	} ctl_t;

endpackage

@@ hdl/spq_in_if.sv @@
// ----------------------------------------------------------------------------
// spq_in_if
// Request channel: one operation word per handshake.
// ----------------------------------------------------------------------------
interface spq_in_if import spq_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [1:0]                operation;
	logic signed [VALUE_W-1:0] item_value;
	logic [PRIO_W-1:0]         item_priority;

	modport source (output valid, operation, item_value, item_priority, input ready);
	modport sink (input valid, operation, item_value, item_priority, output ready);
endinterface

@@ hdl/spq_out_if.sv @@
// ----------------------------------------------------------------------------
// spq_out_if
// Response channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface spq_out_if import spq_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [2:0]                status;
	logic signed [VALUE_W-1:0] out_value;
	logic [PRIO_W-1:0]         out_priority;
	logic                      last_item;

	modport source (output valid, status, out_value, out_priority, last_item, input ready);
	modport sink (input valid, status, out_value, out_priority, last_item, output ready);
endinterface

@@ hdl/stable_priority_queue.sv @@
// Enqueue: each stored entry with a larger priority number is read and shifted up one
// slot, then the new item is written (directly when the queue is empty).
// Dequeue reads the head entry, then returns it; overflow/underflow/empty return a status
// word; a reserved code returns nothing. Traverse reads and returns each entry in turn; the
// next request is taken back in idle. A word held in the output register stalls a result load.
// Reset (arst_n low) empties the queue; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue, ascending priority, FIFO among equal priorities.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_priority_queue import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_in_if.sink    in_ch,
	spq_out_if.source out_ch
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	stat_t st;
	ctl_t  ctl;

	logic [AW-1:0]             head_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             pos_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             pos_m1;
	logic signed [VALUE_W-1:0] val_q;
	logic [PRIO_W-1:0]         prio_q;

	logic [AW-1:0]      lidx;
	logic [AW-1:0]      phys;
	logic [ENTRY_W-1:0] wr_data;
	logic [ENTRY_W-1:0] rd_data;
	logic [PRIO_W-1:0]  rd_prio;
	logic [VALUE_W-1:0] rd_val;

	logic                      out_valid_q;
	status_t                   out_status_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [PRIO_W-1:0]         out_prio_q;
	logic                      out_last_q;

	assign pos_m1  = pos_q - 1'b1;
	assign rd_prio = rd_data[ENTRY_W-1:VALUE_W];
	assign rd_val  = rd_data[VALUE_W-1:0];
	assign wr_data = ctl.wr_item ? {prio_q, val_q} : rd_data;

	always_comb begin
		unique case (ctl.asel)
			AS_POS:   lidx = pos_q[AW-1:0];
			AS_POSM1: lidx = pos_m1[AW-1:0];
			AS_IDX:   lidx = idx_q[AW-1:0];
			AS_HEAD:  lidx = '0;
			default:  lidx = '0;
		endcase
	end

	always_comb begin
		st.in_valid = in_ch.valid;
		st.op       = op_t'(in_ch.operation);
		st.full     = (count_q == CW'(QUEUE_DEPTH));
		st.empty    = (count_q == '0);
		st.pos_one  = (pos_q == CW'(1));
		st.gt       = (rd_prio > prio_q);
		st.out_free = !out_valid_q || out_ch.ready;
		st.idx_last = (idx_q == count_q - 1'b1);
	end

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctl    (ctl)
	);

	spq_agu #(
		.DEPTH (QUEUE_DEPTH)
	) u_agu (
		.head (head_q),
		.lidx (lidx),
		.phys (phys)
	);

	spq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ctl.wr_en),
		.wr_addr (phys),
		.wr_data (wr_data),
		.rd_en   (ctl.rd_en),
		.rd_addr (phys),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.item_ld) begin
				pos_q <= count_q;
				idx_q <= '0;
			end else begin
				if (ctl.pos_dec) begin
					pos_q <= pos_m1;
				end
				if (ctl.idx_inc) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (ctl.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (ctl.head_inc) begin
				head_q <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (ctl.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.item_ld) begin
			val_q  <= in_ch.item_value;
			prio_q <= in_ch.item_priority;
		end
		if (ctl.out_ld) begin
			out_status_q <= ctl.out_status;
			out_value_q  <= ctl.out_data ? rd_val : '0;
			out_prio_q   <= ctl.out_data ? rd_prio : '0;
			out_last_q   <= ctl.out_last;
		end
	end

	assign in_ch.ready         = ctl.in_ready;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = out_status_q;
	assign out_ch.out_value    = out_value_q;
	assign out_ch.out_priority = out_prio_q;
	assign out_ch.last_item    = out_last_q;

	`SPQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH), "count above depth")
	`SPQ_ASSERT_IMP(a_wr_not_full, clk, arst_n, ctl.wr_en, !st.full, "write into full queue")
	`SPQ_ASSERT_IMP(a_ld_free, clk, arst_n, ctl.out_ld, st.out_free, "result overwrites held word")
	`SPQ_ASSERT_NXT(a_deq_count, clk, arst_n, ctl.cnt_dec, count_q + 1'b1 == $past(count_q), "bad dequeue count")

endmodule

@@ hdl/spq_ram.sv @@
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hdl/spq_agu.sv @@
// ----------------------------------------------------------------------------
// spq_agu
// Ring address unit: head pointer plus logical index, wrapped at depth.
// ----------------------------------------------------------------------------
module spq_agu import spq_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic [$clog2(DEPTH)-1:0] head,
	input  logic [$clog2(DEPTH)-1:0] lidx,
	output logic [$clog2(DEPTH)-1:0] phys
);

	localparam int AW = $clog2(DEPTH);

	logic [AW:0] sum;

	always_comb begin
		sum = {1'b0, head} + {1'b0, lidx};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		phys = sum[AW-1:0];
	end

endmodule

@@ hdl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for insert-shift, dequeue and traverse over the shared RAM address.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t st,
	output ctl_t  ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (st.in_valid) begin
					unique case (st.op)
						OP_ENQ: begin
							if (st.full) begin
								state_d = S_OVF;
							end else if (st.empty) begin
								state_d = S_INS;
							end else begin
								state_d = S_ERD;
							end
						end
						OP_DEQ: state_d = st.empty ? S_UND : S_DRD;
						OP_TRV: state_d = st.empty ? S_EMP : S_TRD;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ERD: state_d = S_ECMP;
			S_ECMP: begin
				if (st.gt && !st.pos_one) begin
					state_d = S_ERD;
				end else begin
					state_d = S_INS;
				end
			end
			S_DRD: state_d = S_DOUT;
			S_TRD: state_d = S_TOUT;
			S_TOUT: begin
				if (st.out_free) begin
					state_d = st.idx_last ? S_IDLE : S_TRD;
				end
			end
			S_INS, S_DOUT, S_OVF, S_UND, S_EMP: begin
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl            = '0;
		ctl.asel       = AS_POS;
		ctl.out_status = ST_INSERTED;
		ctl.out_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				ctl.in_ready = 1'b1;
				ctl.item_ld  = st.in_valid;
			end
			S_ERD: begin
				ctl.rd_en = 1'b1;
				ctl.asel  = AS_POSM1;
			end
			S_ECMP: begin
				ctl.wr_en   = st.gt;
				ctl.pos_dec = st.gt;
			end
			S_INS: begin
				ctl.wr_en   = st.out_free;
				ctl.wr_item = 1'b1;
				ctl.cnt_inc = st.out_free;
				ctl.out_ld  = st.out_free;
			end
			S_DRD: begin
				ctl.rd_en = 1'b1;
				ctl.asel  = AS_HEAD;
			end
			S_DOUT: begin
				ctl.out_ld     = st.out_free;
				ctl.out_status = ST_REMOVED;
				ctl.out_data   = 1'b1;
				ctl.head_inc   = st.out_free;
				ctl.cnt_dec    = st.out_free;
			end
			S_TRD: begin
				ctl.rd_en = 1'b1;
				ctl.asel  = AS_IDX;
			end
			S_TOUT: begin
				ctl.out_ld     = st.out_free;
				ctl.out_status = ST_LISTED;
				ctl.out_data   = 1'b1;
				ctl.out_last   = st.idx_last;
				ctl.idx_inc    = st.out_free;
			end
			S_OVF: begin
				ctl.out_ld     = st.out_free;
				ctl.out_status = ST_OVERFLOW;
			end
			S_UND: begin
				ctl.out_ld     = st.out_free;
				ctl.out_status = ST_UNDERFLOW;
			end
			S_EMP: begin
				ctl.out_ld     = st.out_free;
				ctl.out_status = ST_EMPTY;
			end
			default: ctl.asel = AS_POS;
		endcase
	end

endmodule

@@ bench/stable_priority_queue_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb
// Drives random and corner-case requests into the priority queue and checks
// every result word against a sorted-list predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
	import spq_pkg::*;

	localparam int DEPTH           = QUEUE_DEPTH_DEF;
	localparam int RANDOM_REQUESTS = 350;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 2 + 2 * DEPTH + 16;
	localparam int WATCHDOG_LIMIT  = 4000;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]         prio;
	} entry_t;

	typedef struct {
		status_t                   status;
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]         prio;
		logic                      last;
	} result_t;

	class spq_scoreboard;
		entry_t  held[$];
		result_t expected_words[$];
		int      errors;
		int      checked;
		int      requests[4];
		int      status_count[6];

		function void add_expected(status_t st, logic signed [VALUE_W-1:0] value,
			logic [PRIO_W-1:0] prio, logic last);
			result_t r;
			r.status = st;
			r.value  = value;
			r.prio   = prio;
			r.last   = last;
			expected_words.push_back(r);
			status_count[st]++;
		endfunction

		function void note_request(op_t op, logic signed [VALUE_W-1:0] value,
			logic [PRIO_W-1:0] prio);
			int     pos;
			entry_t e;
			requests[op]++;
			case (op)
			OP_ENQ: begin
				if (held.size() >= DEPTH) begin
					add_expected(ST_OVERFLOW, 0, 0, 1'b1);
				end else begin
					pos = held.size();
					while (pos > 0 && held[pos-1].prio > prio)
						pos--;
					e.value = value;
					e.prio  = prio;
					held.insert(pos, e);
					add_expected(ST_INSERTED, 0, 0, 1'b1);
				end
			end
			OP_DEQ: begin
				if (held.size() == 0) begin
					add_expected(ST_UNDERFLOW, 0, 0, 1'b1);
				end else begin
					e = held.pop_front();
					add_expected(ST_REMOVED, e.value, e.prio, 1'b1);
				end
			end
			OP_TRV: begin
				if (held.size() == 0)
					add_expected(ST_EMPTY, 0, 0, 1'b1);
				else
					foreach (held[i])
						add_expected(ST_LISTED, held[i].value, held[i].prio,
							i == held.size() - 1);
			end
			default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			$display("[%0t] MISMATCH %s", $time, what);
			errors++;
		endtask

		task check_word(logic [2:0] st, logic signed [VALUE_W-1:0] value,
			logic [PRIO_W-1:0] prio, logic last);
			result_t w;
			checked++;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word status=%0d value=%0d prio=%0d",
					st, value, prio));
			end else begin
				w = expected_words.pop_front();
				if (st !== w.status)
					report_mismatch($sformatf("status got %0d want %0d", st, w.status));
				if (value !== w.value)
					report_mismatch($sformatf("value got %0d want %0d", value, w.value));
				if (prio !== w.prio)
					report_mismatch($sformatf("priority got %0d want %0d", prio, w.prio));
				if (last !== w.last)
					report_mismatch($sformatf("last got %0b want %0b", last, w.last));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	spq_in_if  in_ch();
	spq_out_if out_ch();

	stable_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	spq_scoreboard sb;
	bit            calm;
	bit            hold_off_req;
	int            idle_cycles;
	int            stall_left;
	int            sent;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(op_t op, logic signed [VALUE_W-1:0] value,
		logic [PRIO_W-1:0] prio);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.operation     <= op;
		in_ch.item_value    <= value;
		in_ch.item_priority <= prio;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(op, value, prio);
	endtask

	function automatic logic [PRIO_W-1:0] pick_prio();
		if ($urandom_range(0, 1))
			return PRIO_W'($urandom_range(0, 255));
		return PRIO_W'($urandom_range(10, 13));
	endfunction

	// result side: random stalls, plus one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		stall_left   = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_word(out_ch.status, out_ch.out_value, out_ch.out_priority,
					out_ch.last_item);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("stable_priority_queue verification failed");
		$finish;
	end

	initial begin
		op_t op;
		bit  filling;
		int  r;

		sb                  = new;
		calm                = 1'b0;
		hold_off_req        = 1'b0;
		arst_n              = 1'b0;
		in_ch.valid         = 1'b0;
		in_ch.operation     = OP_ENQ;
		in_ch.item_value    = '0;
		in_ch.item_priority = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases: empty queue, reserved code, extremes, ties, full queue
		send_word(OP_TRV, 0, 0);
		send_word(OP_DEQ, 32'h1234_5678, 8'hA5);
		send_word(OP_RSV, 32'hFFFF_FFFF, 8'hFF);
		send_word(OP_ENQ, 32'h7FFF_FFFF, 8'd255);
		send_word(OP_ENQ, 32'h8000_0000, 8'd0);
		send_word(OP_ENQ, 0, 8'd128);
		send_word(OP_ENQ, -1, 8'd128);
		send_word(OP_ENQ, 32'h5555_AAAA, 8'd255);
		send_word(OP_TRV, 0, 0);
		repeat (DEPTH - 5)
			send_word(OP_ENQ, $urandom, pick_prio());
		send_word(OP_ENQ, 32'h0BAD_F00D, 8'd1);
		send_word(OP_TRV, 0, 0);
		send_word(OP_RSV, 0, 0);
		send_word(OP_DEQ, 0, 0);
		send_word(OP_DEQ, 0, 0);

		// random traffic, alternating fill and drain bias
		filling = 1'b1;
		sent    = 0;
		while (sent < RANDOM_REQUESTS) begin
			if (sent == 120)
				hold_off_req = 1'b1;
			calm = (sent >= 200 && sent < 260);
			if (sb.held.size() >= DEPTH || $urandom_range(0, 39) == 0)
				filling = 1'b0;
			else if (sb.held.size() == 0 || $urandom_range(0, 39) == 0)
				filling = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 2)
				op = OP_RSV;
			else if (r < 12)
				op = OP_TRV;
			else if (r < (filling ? 75 : 35))
				op = OP_ENQ;
			else
				op = OP_DEQ;
			send_word(op, $urandom, pick_prio());
			if (op != OP_RSV)
				sent++;
		end
		in_ch.valid <= 1'b0;

		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d enqueues, %0d dequeues, %0d traversals, %0d reserved codes",
			sb.requests[OP_ENQ], sb.requests[OP_DEQ], sb.requests[OP_TRV],
			sb.requests[OP_RSV]);
		$display("%0d result words checked: %0d overflow, %0d underflow, %0d empty, %0d errors",
			sb.checked, sb.status_count[ST_OVERFLOW], sb.status_count[ST_UNDERFLOW],
			sb.status_count[ST_EMPTY], sb.errors);
		if (sb.errors == 0)
			$display("stable_priority_queue verification clean");
		else
			$display("stable_priority_queue verification failed");
		$finish;
	end

endmodule
